// File: rtl/pare_pkg.sv
// ----------------------------------------------------------------------------
// pare_pkg: shared types and constants for primitive assembly ray emit
// Command codes, mode codes, result kinds and the front/back request struct.
// ----------------------------------------------------------------------------
package pare_pkg;

    typedef enum logic [2:0] {
        FN_BEGIN  = 3'd0,
        FN_END    = 3'd1,
        FN_VERTEX = 3'd2,
        FN_NORMAL = 3'd3,
        FN_COLOR  = 3'd4,
        FN_LWIDTH = 3'd5,
        FN_WSCALE = 3'd6,
        FN_SPHERE = 3'd7
    } func_t;

    localparam logic [3:0] MODE_POINTS = 4'd0;
    localparam logic [3:0] MODE_LINES  = 4'd1;
    localparam logic [3:0] MODE_LOOP   = 4'd2;
    localparam logic [3:0] MODE_STRIP  = 4'd3;
    localparam logic [3:0] MODE_TRIS   = 4'd4;
    localparam logic [3:0] MODE_TSTRIP = 4'd5;
    localparam logic [3:0] MODE_FAN    = 4'd6;
    localparam logic [3:0] MODE_NONE   = 4'd15;

    typedef enum logic [1:0] {
        KIND_COLOR  = 2'd0,
        KIND_SPHERE = 2'd1,
        KIND_CYL    = 2'd2,
        KIND_TRI    = 2'd3
    } kind_t;

    localparam logic signed [31:0] ONE_Q       = 32'sd65536;
    localparam logic signed [31:0] SCALE_RESET = 32'sd9830;

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        q_t x;
        q_t y;
        q_t z;
    } vec_t;

    // One result item as sent on the output channel.
    typedef struct packed {
        kind_t kind;
        logic  last;
        vec_t  pos;
        vec_t  col;
        vec_t  nrm;
        q_t    rad;
    } item_t;

    // One classified request: up to three items, count in cnt.
    typedef struct packed {
        logic [1:0] cnt;
        item_t      i0;
        item_t      i1;
        item_t      i2;
    } req_t;

endpackage

// File: rtl/primitive_assembly_ray_emit_unit.sv
// ----------------------------------------------------------------------------
// primitive_assembly_ray_emit_unit: primitive assembly for a ray tracer
// Turn drawing commands into color, sphere, cylinder-end and triangle items.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------
//  command  | in_valid / in_stall    | func, coord_x..z, scalar_value, mode
//  result   | out_valid / out_stall  | kind, last, pos, color, normal, radius
//
// A command is taken when in_valid is high and in_stall low; the front decodes
// it against the primitive state and queues a request of one to three result
// items. The back sends one item per unstalled cycle, so a triangle-producing
// vertex yields three items. Commands with no result only update state. The
// width product is stored at the edge that accepts the width command, so the
// very next request sees it. Reset sets all control state at once; no sweep.
// in_stall rises when the queue nears full; out_stall holds the current item.
module primitive_assembly_ray_emit_unit #(
    parameter int QDEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          func,
    input  logic signed [31:0]  coord_x,
    input  logic signed [31:0]  coord_y,
    input  logic signed [31:0]  coord_z,
    input  logic signed [31:0]  scalar_value,
    input  logic [3:0]          draw_mode,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic                last,
    output logic signed [31:0]  pos_x,
    output logic signed [31:0]  pos_y,
    output logic signed [31:0]  pos_z,
    output logic signed [31:0]  red,
    output logic signed [31:0]  green,
    output logic signed [31:0]  blue,
    output logic signed [31:0]  norm_x,
    output logic signed [31:0]  norm_y,
    output logic signed [31:0]  norm_z,
    output logic signed [31:0]  radius
);
    import pare_pkg::*;

    logic  in_fire, q_empty, q_afull, q_pop, push_reg;
    req_t  req, req_reg, head;
    item_t it;
    vec_t  coord;

    assign coord    = '{x: coord_x, y: coord_y, z: coord_z};
    assign in_stall = q_afull;
    assign in_fire  = in_valid && !in_stall;

    pare_front u_front (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .func(func),
        .coord(coord), .scalar_value(scalar_value), .draw_mode(draw_mode),
        .req(req)
    );

    // Register the decoded request before the queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            push_reg <= 1'b0;
        else
            push_reg <= in_fire && (req.cnt != 2'd0);
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req;
    end

    pare_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push_reg), .wdata(req_reg),
        .pop(q_pop), .rdata(head), .empty(q_empty), .afull(q_afull)
    );

    pare_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .empty(q_empty), .pop(q_pop),
        .stall(out_stall), .valid(out_valid), .item(it)
    );

    assign kind   = it.kind;
    assign last   = it.last;
    assign pos_x  = it.pos.x;
    assign pos_y  = it.pos.y;
    assign pos_z  = it.pos.z;
    assign red    = it.col.x;
    assign green  = it.col.y;
    assign blue   = it.col.z;
    assign norm_x = it.nrm.x;
    assign norm_y = it.nrm.y;
    assign norm_z = it.nrm.z;
    assign radius = it.rad;

endmodule

// File: rtl/pare_front.sv
// ----------------------------------------------------------------------------
// pare_front: command decode and primitive state
// Track mode, counts, history and width; build the items for each command.
// ----------------------------------------------------------------------------
module pare_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [2:0]       func,
    input  pare_pkg::vec_t   coord,
    input  pare_pkg::q_t     scalar_value,
    input  logic [3:0]       draw_mode,
    output pare_pkg::req_t   req
);
    import pare_pkg::*;

    logic [3:0] mode_reg, mode_next;
    logic [1:0] m3_reg, m3_next;
    logic       odd_reg, odd_next, s1_reg, s1_next, s2_reg, s2_next;
    vec_t       v_reg [3];
    vec_t       c_reg [3];
    vec_t       n_reg [3];
    vec_t       v_next [3];
    vec_t       c_next [3];
    vec_t       n_next [3];
    q_t         lw_reg, lw_next, ws_reg, ws_next, pw_reg;
    logic       wupd_next;
    logic signed [63:0] prod;
    logic signed [63:0] quo;

    function automatic item_t mk(kind_t k, vec_t p, vec_t c, vec_t n, q_t r);
        item_t it;
        it.kind = k;
        it.last = 1'b0;
        it.pos  = p;
        it.col  = c;
        it.nrm  = n;
        it.rad  = r;
        return it;
    endfunction

    localparam vec_t ZV = '0;

    always_comb
    begin
        mode_next = mode_reg;
        m3_next   = m3_reg;
        odd_next  = odd_reg;
        s1_next   = s1_reg;
        s2_next   = s2_reg;
        v_next    = v_reg;
        c_next    = c_reg;
        n_next    = n_reg;
        lw_next   = lw_reg;
        ws_next   = ws_reg;
        wupd_next = 1'b0;
        req       = '0;
        if (in_fire)
        begin
            case (func_t'(func))
                FN_BEGIN:
                begin
                    mode_next = draw_mode;
                    m3_next = '0;
                    odd_next = 1'b0;
                    s1_next = 1'b0;
                    s2_next = 1'b0;
                    n_next[0] = '{x: '0, y: '0, z: ONE_Q};
                end
                FN_END:
                begin
                    if (mode_reg == MODE_LOOP && s2_reg)
                    begin
                        req.cnt = 2'd2;
                        req.i0 = mk(KIND_CYL, v_reg[1], c_reg[1], ZV, pw_reg);
                        req.i1 = mk(KIND_CYL, v_reg[2], c_reg[2], ZV, pw_reg);
                    end
                    mode_next = MODE_NONE;
                end
                FN_VERTEX:
                begin
                    v_next[0] = coord;
                    case (mode_reg)
                        MODE_POINTS:
                        begin
                            req.cnt = 2'd1;
                            req.i0 = mk(KIND_SPHERE, coord, c_reg[0], ZV, pw_reg);
                        end
                        MODE_LINES, MODE_STRIP, MODE_LOOP:
                        begin
                            if ((mode_reg == MODE_LINES) ? odd_reg : s1_reg)
                            begin
                                req.cnt = 2'd2;
                                req.i0 = mk(KIND_CYL, coord, c_reg[0], ZV, pw_reg);
                                req.i1 = mk(KIND_CYL, v_reg[1], c_reg[1], ZV, pw_reg);
                            end
                            else if (mode_reg == MODE_LOOP)
                            begin
                                v_next[2] = coord;
                                c_next[2] = c_reg[0];
                            end
                            v_next[1] = coord;
                            c_next[1] = c_reg[0];
                        end
                        MODE_TRIS, MODE_TSTRIP:
                        begin
                            if ((mode_reg == MODE_TRIS) ? (m3_reg == 2'd2) : s2_reg)
                            begin
                                req.cnt = 2'd3;
                                req.i0 = mk(KIND_TRI, coord, c_reg[0], n_reg[0], '0);
                                req.i1 = mk(KIND_TRI, v_reg[1], c_reg[1], n_reg[1], '0);
                                req.i2 = mk(KIND_TRI, v_reg[2], c_reg[2], n_reg[2], '0);
                            end
                            v_next[2] = v_reg[1];
                            c_next[2] = c_reg[1];
                            n_next[2] = n_reg[1];
                            v_next[1] = coord;
                            c_next[1] = c_reg[0];
                            n_next[1] = n_reg[0];
                        end
                        MODE_FAN:
                        begin
                            if (s2_reg)
                            begin
                                req.cnt = 2'd3;
                                req.i0 = mk(KIND_TRI, coord, c_reg[0], n_reg[0], '0);
                                req.i1 = mk(KIND_TRI, v_reg[1], c_reg[1], n_reg[1], '0);
                                req.i2 = mk(KIND_TRI, v_reg[2], c_reg[2], n_reg[2], '0);
                            end
                            else if (!s1_reg)
                            begin
                                v_next[2] = coord;
                                c_next[2] = c_reg[0];
                                n_next[2] = n_reg[0];
                            end
                            v_next[1] = coord;
                            c_next[1] = c_reg[0];
                            n_next[1] = n_reg[0];
                        end
                        default:
                        begin
                        end
                    endcase
                    m3_next = (m3_reg >= 2'd2) ? 2'd0 : m3_reg + 2'd1;
                    odd_next = ~odd_reg;
                    s2_next = s2_reg | s1_reg;
                    s1_next = 1'b1;
                end
                FN_NORMAL:
                    n_next[0] = coord;
                FN_COLOR:
                begin
                    c_next[0] = coord;
                    req.cnt = 2'd1;
                    req.i0 = mk(KIND_COLOR, ZV, coord, ZV, '0);
                end
                FN_LWIDTH:
                begin
                    lw_next = scalar_value;
                    wupd_next = 1'b1;
                end
                FN_WSCALE:
                begin
                    ws_next = scalar_value;
                    wupd_next = 1'b1;
                end
                default:
                begin
                    req.cnt = 2'd2;
                    req.i0 = mk(KIND_COLOR, ZV, c_reg[0], ZV, '0);
                    req.i1 = mk(KIND_SPHERE, coord, c_reg[0], ZV, scalar_value);
                end
            endcase
            case (req.cnt)
                2'd1: req.i0.last = 1'b1;
                2'd2: req.i1.last = 1'b1;
                2'd3: req.i2.last = 1'b1;
                default: ;
            endcase
        end
    end

    // Width product: truncate toward zero (round a negative remainder up),
    // saturate to 32 bits when stored.
    always_comb
    begin
        prod = 64'(ws_next) * 64'(lw_next);
        quo  = (prod >>> 16) + ((prod[63] && (prod[15:0] != 16'd0)) ? 64'sd1 : 64'sd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NONE;
            m3_reg   <= '0;
            odd_reg  <= 1'b0;
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= '0;
                c_reg[i] <= '0;
                n_reg[i] <= '0;
            end
            c_reg[0] <= '{x: ONE_Q, y: ONE_Q, z: ONE_Q};
            n_reg[0] <= '{x: '0, y: '0, z: ONE_Q};
            lw_reg   <= ONE_Q;
            ws_reg   <= SCALE_RESET;
            pw_reg   <= SCALE_RESET;
        end
        else
        begin
            mode_reg <= mode_next;
            m3_reg   <= m3_next;
            odd_reg  <= odd_next;
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            v_reg    <= v_next;
            c_reg    <= c_next;
            n_reg    <= n_next;
            lw_reg   <= lw_next;
            ws_reg   <= ws_next;
            if (wupd_next)
            begin
                if (quo > 64'sd2147483647)
                    pw_reg <= 32'sh7fffffff;
                else if (quo < -64'sd2147483648)
                    pw_reg <= 32'sh80000000;
                else
                    pw_reg <= quo[31:0];
            end
        end
    end

endmodule

// File: rtl/pare_queue.sv
// ----------------------------------------------------------------------------
// pare_queue: request queue between front and back
// Small FIFO of classified requests; almost-full stalls the front.
// ----------------------------------------------------------------------------
module pare_queue #(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pare_pkg::req_t wdata,
    input  logic           pop,
    output pare_pkg::req_t rdata,
    output logic           empty,
    output logic           afull
);
    import pare_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t         mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   n_reg;

    assign empty = (n_reg == '0);
    // Leave room for a request already decoded in flight.
    assign afull = (n_reg >= (AW+1)'(DEPTH - 1));
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            n_reg <= n_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

// File: rtl/pare_back.sv
// ----------------------------------------------------------------------------
// pare_back: result sequencer
// Step through the items of the head request, one per accepted output.
// ----------------------------------------------------------------------------
module pare_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  pare_pkg::req_t head,
    input  logic           empty,
    output logic           pop,
    input  logic           stall,
    output logic           valid,
    output pare_pkg::item_t item
);
    import pare_pkg::*;

    logic [1:0] idx_reg;
    logic       fire;

    assign valid = !empty;
    assign fire  = valid && !stall;
    assign pop   = fire && (idx_reg == head.cnt - 2'd1);

    always_comb
    begin
        case (idx_reg)
            2'd0:    item = head.i0;
            2'd1:    item = head.i1;
            default: item = head.i2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (pop)
            idx_reg <= '0;
        else if (fire)
            idx_reg <= idx_reg + 2'd1;
    end

endmodule
